// ----- design/lru_page_replacement_top_defines.svh -----
// Assertion macros shared by the page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LRUPR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define LRUPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lrupr_pkg.sv -----
// Shared types and constants for the page replacement block.
`default_nettype none

package lrupr_pkg;

  localparam int CFG_W   = 4;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load_page;
    logic eval;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/lrupr_req_if.sv -----
// Request channel: one page reference per beat.
`default_nettype none

interface lrupr_req_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

`default_nettype wire

// ----- design/lrupr_rsp_if.sv -----
// Response channel: one lookup result per beat.
`default_nettype none

interface lrupr_rsp_if #(
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 3
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IDX_W-1:0]     frame_index;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [31:0]          fault_count;

  modport source (
    output valid, output hit, output frame_index, output evicted_valid,
    output evicted_page, output fault_count, input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted_valid,
    input evicted_page, input fault_count, output ready
  );
endinterface

`default_nettype wire

// ----- design/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement table.
// An accepted request beat passes through the lookup state and then the commit state,
// which loads the result register and raises the response valid.
// A new request is taken in the commit cycle; an untaken result holds commit and input.
// Reset (rst, synchronous) empties all frames, clears the use and fault counters,
// and sets the frame count to eight.
`default_nettype none

module lru_page_replacement_top #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  lrupr_req_if.sink                        req,
  lrupr_rsp_if.source                      rsp
);
  import lrupr_pkg::*;

  // Width of a frame index, at least one bit even for a single frame.
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  cmd_t cmd;

  // The sequencer walks each beat through two phases. In the lookup phase
  // every active frame compares its page and stamp in parallel and the
  // outcome is registered. In the commit phase the frame is chosen (hit,
  // lowest empty, or oldest), the table is written and the result register
  // is loaded, provided the previous result has been taken.
  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // The datapath holds the frame table, the counters, the frame count
  // register and the result register that drives the response payload.
  lrupr_dpath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .page_in           (req.page_number),
    .rsp_hit           (rsp.hit),
    .rsp_frame_index   (rsp.frame_index),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_fault_count   (rsp.fault_count)
  );

endmodule

`default_nettype wire

// ----- design/lrupr_ctrl.sv -----
// Sequencer for the page replacement block: lookup, commit and response valid.
`default_nettype none
`include "lru_page_replacement_top_defines.svh"

module lrupr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output lrupr_pkg::cmd_t    cmd
);
  import lrupr_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   accept;

  // The response register can take a new beat when empty or being drained.
  assign slot_free = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) state_next = accept ? S_LOOK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_LOOK: begin
        cmd.eval = 1'b1;
      end
      S_COMMIT: begin
        req_ready  = slot_free;
        cmd.commit = slot_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    cmd.load_page = req_valid && req_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `LRUPR_ASSERT_SAME(a_accept_state, accept, (state == S_IDLE || state == S_COMMIT), "request accepted while a lookup is in flight")
  `LRUPR_ASSERT_NEXT(a_accept_look, accept, state == S_LOOK, "accepted request did not start a lookup")
  `LRUPR_ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_valid, "committed result not presented")
  `LRUPR_ASSERT_SAME(a_commit_free, cmd.commit, slot_free, "commit would overwrite an untaken result")

endmodule

`default_nettype wire

// ----- design/lrupr_dpath.sv -----
// Frame table, parallel lookup and victim selection, and the result register.
`default_nettype none
`include "lru_page_replacement_top_defines.svh"

module lrupr_dpath #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lrupr_pkg::cmd_t             cmd,
  input  wire logic                        cfg_we,
  input  wire logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic [PAGE_BITS-1:0]        page_in,
  output logic                             rsp_hit,
  output logic [IDX_W-1:0]                 rsp_frame_index,
  output logic                             rsp_evicted_valid,
  output logic [PAGE_BITS-1:0]             rsp_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]    rsp_fault_count
);
  import lrupr_pkg::*;

  localparam int NW = $clog2(FRAMES + 1);

  // Frame table. Valid bits reset; pages and stamps are written before use.
  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [STAMP_W-1:0]   use_stamp  [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [STAMP_W-1:0]   use_counter;
  logic [COUNT_W-1:0]   faults;
  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] page;

  // Lookup results held between the two phases.
  logic [FRAMES-1:0] match_r;
  logic [FRAMES-1:0] empty_r;
  logic [FRAMES-1:0] oldest_r;

  logic [NW-1:0]        n_act;
  logic [FRAMES-1:0]    active;
  logic [FRAMES-1:0]    match_v;
  logic [FRAMES-1:0]    empty_v;
  logic [FRAMES-1:0]    oldest_v;
  logic [FRAMES-1:0]    sel;
  logic                 hit_c;
  logic                 evict_c;
  logic [PAGE_BITS-1:0] ev_page_c;
  logic [STAMP_W-1:0]   use_counter_next;
  logic [COUNT_W-1:0]   faults_next;

  function automatic logic [FRAMES-1:0] lowest_set(input logic [FRAMES-1:0] v);
    return v & (~v + FRAMES'(1));
  endfunction

  function automatic logic [IDX_W-1:0] encode(input logic [FRAMES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (v[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

  // Clamp the programmed frame count into 1..FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      n_act = NW'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(frames_in_use);
    end
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = int'(n_act) > i;
    end
  end

  // Every frame compares in parallel; the oldest frame is the one whose
  // stamp is below all lower frames and not above any higher frame.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match_v[i]  = active[i] && frame_valid[i] && (frame_page[i] == page);
      empty_v[i]  = active[i] && !frame_valid[i];
      oldest_v[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (j < i && active[j]) begin
          oldest_v[i] = oldest_v[i] && (use_stamp[i] < use_stamp[j]);
        end else if (j > i && active[j]) begin
          oldest_v[i] = oldest_v[i] && (use_stamp[i] <= use_stamp[j]);
        end
      end
    end
  end

  // Commit phase: choose the frame and gather the page being evicted.
  always_comb begin
    hit_c   = |match_r;
    evict_c = !hit_c && !(|empty_r);
    if (hit_c) begin
      sel = lowest_set(match_r);
    end else if (!evict_c) begin
      sel = lowest_set(empty_r);
    end else begin
      sel = oldest_r;
    end
    ev_page_c = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (evict_c && oldest_r[i]) ev_page_c = ev_page_c | frame_page[i];
    end
    use_counter_next = (use_counter == STAMP_MAX) ? use_counter : use_counter + STAMP_W'(1);
    faults_next      = (hit_c || faults == COUNT_MAX) ? faults : faults + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      use_counter   <= '0;
      faults        <= '0;
      frames_in_use <= CFG_RESET;
    end else begin
      if (cfg_we) frames_in_use <= cfg_wdata;
      if (cmd.commit) begin
        use_counter <= use_counter_next;
        faults      <= faults_next;
        frame_valid <= frame_valid | sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_page) page <= page_in;
    if (cmd.eval) begin
      match_r  <= match_v;
      empty_r  <= empty_v;
      oldest_r <= oldest_v;
    end
    if (cmd.commit) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (sel[i]) begin
          frame_page[i] <= page;
          use_stamp[i]  <= use_counter_next;
        end
      end
      rsp_hit           <= hit_c;
      rsp_frame_index   <= encode(sel);
      rsp_evicted_valid <= evict_c;
      rsp_evicted_page  <= ev_page_c;
      rsp_fault_count   <= faults_next;
    end
  end

  `LRUPR_ASSERT_SAME(a_sel_onehot, cmd.commit, $onehot(sel), "commit does not select exactly one frame")
  `LRUPR_ASSERT_NEXT(a_hit_no_fault, cmd.commit && hit_c, faults == $past(faults), "fault counted on a hit")
  `LRUPR_ASSERT_NEXT(a_fault_mono, cmd.commit, faults >= $past(faults), "fault count went backward")

endmodule

`default_nettype wire
